// ===== rtl/egbw_pkg.sv =====
// ----------------------------------------------------------------------------
// egbw_pkg
// Shared types and constants for the Exp-Golomb bit writer: operation codes,
// the command that travels from the front end to the packer, and field widths.
// ----------------------------------------------------------------------------
package egbw_pkg;

    localparam int WORD_BITS = 32;
    localparam int CNT_W     = 6;
    localparam int FILL_W    = 5;

    // Largest code number; keeps every code at 63 bits or fewer
    localparam logic [WORD_BITS-1:0] CODE_MAX = 32'hFFFF_FFFE;

    // Input operation codes (5..7 are unused and write no bits)
    typedef enum logic [2:0] {
        OP_PUT_BITS = 3'd0,
        OP_UGOLOMB  = 3'd1,
        OP_SGOLOMB  = 3'd2,
        OP_ALIGN    = 3'd3,
        OP_FLUSH    = 3'd4
    } t_op;

    // Command kinds seen by the packer
    typedef enum logic [1:0] {
        CMD_PUT,
        CMD_ALIGN,
        CMD_FLUSH,
        CMD_NOP
    } t_kind;

    // One classified command. For CMD_PUT, nbits (0..63) bits are written,
    // with val right-aligned and zeros above it.
    typedef struct packed {
        t_kind                  kind;
        logic [WORD_BITS-1:0]   val;
        logic [CNT_W-1:0]       nbits;
        logic                   abit;
    } t_cmd;

endpackage

// ===== rtl/egbw_front.sv =====
// ----------------------------------------------------------------------------
// egbw_front
// Input side: takes one syntax element per beat and turns it into a packer
// command (field length saturation, signed mapping, Exp-Golomb code length).
// ----------------------------------------------------------------------------
module egbw_front (
    input  logic                    i_valid,
    input  logic [2:0]              i_operation,
    input  logic signed [32:0]      i_value,
    input  logic [5:0]              i_bit_count,
    input  logic                    i_align_bit,
    output logic                    o_ready,
    input  logic                    i_full,
    output logic                    o_push,
    output egbw_pkg::t_cmd          o_cmd
);
    import egbw_pkg::*;

    logic [33:0]          sv_ext;
    logic [33:0]          mapped;
    logic [33:0]          code_raw;
    logic [WORD_BITS-1:0] code_sat;
    logic [WORD_BITS-1:0] code_x;
    logic [4:0]           msb;
    logic [CNT_W-1:0]     cnt_sat;

    // handshake into the queue
    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    // signed mapping: v <= 0 -> -2v, v > 0 -> 2v-1
    always_comb begin
        sv_ext = {i_value[32], i_value};
        if (i_value[32] || (i_value == 33'sd0)) begin
            mapped = (34'd0 - sv_ext) << 1;
        end else begin
            mapped = (sv_ext << 1) - 34'd1;
        end
    end

    // code number, saturation, and bit length of codeNum+1
    always_comb begin
        if (i_operation == OP_SGOLOMB) begin
            code_raw = mapped;
        end else begin
            code_raw = {2'b00, i_value[31:0]};
        end
        code_sat = (code_raw > {2'b00, CODE_MAX}) ? CODE_MAX : code_raw[WORD_BITS-1:0];
        code_x   = code_sat + 32'd1;
        msb      = 5'd0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (code_x[i]) begin
                msb = 5'(i);
            end
        end
    end

    assign cnt_sat = (i_bit_count > 6'd32) ? 6'd32 : i_bit_count;

    // build the command
    always_comb begin
        o_cmd.kind  = CMD_NOP;
        o_cmd.val   = '0;
        o_cmd.nbits = '0;
        o_cmd.abit  = i_align_bit;
        case (i_operation)
            OP_PUT_BITS: begin
                o_cmd.kind  = CMD_PUT;
                o_cmd.val   = i_value[31:0];
                o_cmd.nbits = cnt_sat;
            end
            OP_UGOLOMB, OP_SGOLOMB: begin
                // len-1 zeros then codeNum+1 in len bits: 2*len-1 bits in all
                o_cmd.kind  = CMD_PUT;
                o_cmd.val   = code_x;
                o_cmd.nbits = {msb, 1'b1};
            end
            OP_ALIGN: begin
                o_cmd.kind = CMD_ALIGN;
            end
            OP_FLUSH: begin
                o_cmd.kind = CMD_FLUSH;
            end
            default: begin
                o_cmd.kind = CMD_NOP;
            end
        endcase
    end

endmodule

// ===== rtl/egbw_queue.sv =====
// ----------------------------------------------------------------------------
// egbw_queue
// Small command FIFO between the front end and the packer, so each side can
// stall on its own.
// ----------------------------------------------------------------------------
module egbw_queue #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  egbw_pkg::t_cmd  i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output egbw_pkg::t_cmd  o_cmd
);
    import egbw_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== rtl/egbw_back.sv =====
// ----------------------------------------------------------------------------
// egbw_back
// Packer: appends up to 32 bits per cycle to the pending word, emits full
// words, handles byte align and flush, and holds results in an output stage.
// ----------------------------------------------------------------------------
module egbw_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  egbw_pkg::t_cmd  i_cmd,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic            o_word_valid,
    output logic [31:0]     o_out_word,
    output logic            o_last,
    output logic [31:0]     o_total_bits
);
    import egbw_pkg::*;

    logic [WORD_BITS-1:0] r_pending, n_pending;
    logic [FILL_W-1:0]    r_fill, n_fill;
    logic [WORD_BITS-1:0] r_total, n_total;
    logic                 r_phase, n_phase;
    logic                 r_out_valid, n_out_valid;
    logic                 r_word_valid, n_word_valid;
    logic [WORD_BITS-1:0] r_out_word, n_out_word;
    logic                 r_last, n_last;
    logic [WORD_BITS-1:0] r_total_bits, n_total_bits;

    logic [CNT_W-1:0]       room;
    logic                   long_put;
    logic [CNT_W-1:0]       put_n;
    logic [WORD_BITS-1:0]   put_v;
    logic [WORD_BITS-1:0]   v_m;
    logic [2*WORD_BITS-1:0] cat;
    logic [CNT_W-1:0]       rest;
    logic [CNT_W-1:0]       add;
    logic                   last_step;
    logic                   put_emit;
    logic                   flush_emit;
    logic                   emit;
    logic                   fire;
    logic [2:0]             pad;

    assign o_valid      = r_out_valid;
    assign o_word_valid = r_word_valid;
    assign o_out_word   = r_out_word;
    assign o_last       = r_last;
    assign o_total_bits = r_total_bits;

    // step selection: a put longer than 32 bits goes as leading zeros, then 32 bits
    always_comb begin
        room      = 6'd32 - {1'b0, r_fill};
        long_put  = (i_cmd.kind == CMD_PUT) && (i_cmd.nbits > 6'd32);
        pad       = 3'd0 - r_fill[2:0];
        put_n     = '0;
        put_v     = '0;
        add       = '0;
        last_step = 1'b1;
        case (i_cmd.kind)
            CMD_PUT: begin
                add = r_phase ? 6'd0 : i_cmd.nbits;
                if (long_put && !r_phase) begin
                    put_n     = i_cmd.nbits - 6'd32;
                    last_step = 1'b0;
                end else if (long_put) begin
                    put_n = 6'd32;
                    put_v = i_cmd.val;
                end else begin
                    put_n = i_cmd.nbits;
                    put_v = i_cmd.val;
                end
            end
            CMD_ALIGN: begin
                put_n = {3'b000, pad};
                put_v = {WORD_BITS{i_cmd.abit}};
                add   = {3'b000, pad};
            end
            default: begin
                put_n = '0;
            end
        endcase
    end

    // bit append datapath
    always_comb begin
        v_m        = put_v & ~({WORD_BITS{1'b1}} << put_n);
        cat        = ({{WORD_BITS{1'b0}}, r_pending} << put_n) | {{WORD_BITS{1'b0}}, v_m};
        put_emit   = (put_n != '0) && (put_n >= room);
        rest       = put_n - room;
        flush_emit = (i_cmd.kind == CMD_FLUSH) && (r_fill != '0);
        emit       = put_emit || flush_emit;
    end

    assign fire  = i_q_valid && (!r_out_valid || i_ready);
    assign o_pop = fire && last_step;

    // next state and result stage
    always_comb begin
        n_pending    = r_pending;
        n_fill       = r_fill;
        n_total      = r_total;
        n_phase      = r_phase;
        n_out_valid  = r_out_valid && !i_ready;
        n_word_valid = r_word_valid;
        n_out_word   = r_out_word;
        n_last       = r_last;
        n_total_bits = r_total_bits;
        if (fire) begin
            n_total = r_total + {{(WORD_BITS-CNT_W){1'b0}}, add};
            n_phase = !last_step;
            if (flush_emit) begin
                n_pending = '0;
                n_fill    = '0;
            end else if (put_emit) begin
                n_pending = v_m & ~({WORD_BITS{1'b1}} << rest);
                n_fill    = rest[FILL_W-1:0];
            end else if (put_n != '0) begin
                n_pending = cat[WORD_BITS-1:0];
                n_fill    = r_fill + put_n[FILL_W-1:0];
            end
            if (emit || last_step) begin
                n_out_valid  = 1'b1;
                n_word_valid = emit;
                n_last       = last_step;
                n_total_bits = n_total;
                if (flush_emit) begin
                    n_out_word = r_pending << room;
                end else if (put_emit) begin
                    n_out_word = 32'(cat >> rest);
                end else begin
                    n_out_word = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= '0;
            r_fill      <= '0;
            r_total     <= '0;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pending   <= n_pending;
            r_fill      <= n_fill;
            r_total     <= n_total;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_word_valid <= n_word_valid;
        r_out_word   <= n_out_word;
        r_last       <= n_last;
        r_total_bits <= n_total_bits;
    end

endmodule

// ===== rtl/exp_golomb_bit_writer_core.sv =====
// Each command is held in the queue, then its result beat in the result register.
// Throughput: one item per cycle unless the result side stalls; the packer
// appends at most 32 bits per cycle, so it writes an Exp-Golomb code longer
// than 32 bits as its leading zeros first and its last 32 bits after them.
// Reset (synchronous, active low) empties the queue, the pending word,
// the fill count and the bit total.
// ----------------------------------------------------------------------------
// exp_golomb_bit_writer_core
// Packs syntax elements MSB-first into 32-bit words: plain fields, unsigned
// and signed Exp-Golomb codes, byte align and flush. Front end, command queue
// and packer are decoupled so each side can stall on its own.
// ----------------------------------------------------------------------------
module exp_golomb_bit_writer_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [2:0]          i_operation,
    input  logic signed [32:0]  i_value,
    input  logic [5:0]          i_bit_count,
    input  logic                i_align_bit,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_word_valid,
    output logic [31:0]         o_out_word,
    output logic                o_last,
    output logic [31:0]         o_total_bits
);
    import egbw_pkg::*;

    t_cmd front_cmd;
    t_cmd head_cmd;
    logic push;
    logic full;
    logic pop;
    logic q_valid;

    // classify input beats
    egbw_front u_front (
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .i_value     (i_value),
        .i_bit_count (i_bit_count),
        .i_align_bit (i_align_bit),
        .o_ready     (o_ready),
        .i_full      (full),
        .o_push      (push),
        .o_cmd       (front_cmd)
    );

    // command queue
    egbw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    // bit packer and result stage
    egbw_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_cmd        (head_cmd),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_word_valid (o_word_valid),
        .o_out_word   (o_out_word),
        .o_last       (o_last),
        .o_total_bits (o_total_bits)
    );

endmodule

// ===== tb/exp_golomb_bit_writer_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exp_golomb_bit_writer_core_tb
// Drives syntax elements (plain fields, unsigned and signed Exp-Golomb codes,
// byte align, flush, spare codes) with random idle gaps on both channels and
// checks every result beat against a bit-accurate packer model kept here.
// ----------------------------------------------------------------------------
module exp_golomb_bit_writer_core_tb;

    import egbw_pkg::*;

    localparam int         CLK_HALF    = 5;
    localparam int         RESET_CYC   = 7;
    localparam int         MAX_IDLE    = 13;
    localparam int         RAND_ITEMS  = 1425;
    localparam int         HOLD_AT     = 500;
    localparam int         HOLD_CYC    = 300;
    localparam int         DRAIN_CYC   = 20;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         MAX_REPORTS = 10;
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    // One syntax element as offered on the input channel
    typedef struct packed {
        logic [2:0]         op;
        logic signed [32:0] value;
        logic [5:0]         bit_count;
        logic               align_bit;
    } t_element;

    // One beat on the result channel
    typedef struct packed {
        logic        word_valid;
        logic [31:0] word;
        logic        last;
        logic [31:0] total_bits;
    } t_word_beat;

    // Packer model plus the queue of result beats still owed by the block
    class bitstream_scoreboard;
        logic [31:0] pend_word;
        logic [4:0]  fill_bits;
        logic [31:0] stream_bits;
        logic [31:0] done_words[$];
        t_word_beat  expected_beats[$];
        int          mismatch_cnt;

        function new();
            pend_word    = '0;
            fill_bits    = '0;
            stream_bits  = '0;
            mismatch_cnt = 0;
        endfunction

        function logic [63:0] low_ones(int n);
            return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
        endfunction

        // Append n bits (saturated to 32) from the low end of val
        function void pack_field(logic [31:0] val, int n);
            logic [63:0] v;
            logic [63:0] cat;
            int          room;
            int          rest;
            if (n == 0) return;
            if (n > 32) n = 32;
            v = {32'd0, val} & low_ones(n);
            stream_bits = stream_bits + 32'(n);
            room = 32 - int'(fill_bits);
            if (n < room) begin
                cat = ({32'd0, pend_word} << n) | v;
                pend_word = cat[31:0];
                fill_bits = 5'(int'(fill_bits) + n);
            end else begin
                rest = n - room;
                cat = ({32'd0, pend_word} << room) | (v >> rest);
                done_words.push_back(cat[31:0]);
                v = v & low_ones(rest);
                pend_word = v[31:0];
                fill_bits = 5'(rest);
            end
        endfunction

        // Exp-Golomb: leading zeros, then code+1; huge codes saturate
        function void pack_golomb(logic [63:0] code);
            logic [31:0] x;
            int          len;
            if (code > {32'd0, CODE_MAX}) code = {32'd0, CODE_MAX};
            x = code[31:0] + 32'd1;
            len = 0;
            for (int i = 0; i < 32; i++) if (x[i]) len = i + 1;
            pack_field(32'd0, len - 1);
            pack_field(x, len);
        endfunction

        // Model one accepted element and queue the beats it must produce
        function void note_element(t_element e);
            longint      sv;
            logic [63:0] mapped;
            int          pad;
            t_word_beat  b;
            done_words.delete();
            case (e.op)
                OP_PUT_BITS: pack_field(e.value[31:0], int'(e.bit_count));
                OP_UGOLOMB:  pack_golomb({32'd0, e.value[31:0]});
                OP_SGOLOMB: begin
                    sv = longint'($signed(e.value));
                    mapped = (sv <= 0) ? -2 * sv : 2 * sv - 1;
                    pack_golomb(mapped);
                end
                OP_ALIGN: begin
                    pad = (fill_bits[2:0] == 3'd0) ? 0 : 8 - int'(fill_bits[2:0]);
                    pack_field(e.align_bit ? 32'hFFFF_FFFF : 32'd0, pad);
                end
                OP_FLUSH: begin
                    if (fill_bits != 5'd0) begin
                        done_words.push_back(pend_word << (32 - int'(fill_bits)));
                        pend_word = '0;
                        fill_bits = '0;
                    end
                end
                default: ;
            endcase
            // no word completed: a bare bit-count beat
            if (done_words.size() == 0) begin
                b = '{word_valid: 1'b0, word: 32'd0, last: 1'b1, total_bits: stream_bits};
                expected_beats.push_back(b);
            end
            foreach (done_words[k]) begin
                b.word_valid = 1'b1;
                b.word       = done_words[k];
                b.last       = (k == done_words.size() - 1);
                b.total_bits = stream_bits;
                expected_beats.push_back(b);
            end
        endfunction

        function void flag(string what, logic [31:0] want, logic [31:0] got);
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
                $display("mismatch on %s: expected %h, got %h", what, want, got);
        endfunction

        // Compare one result beat, field by field, with the oldest expectation
        function void check_word_beat(t_word_beat got);
            t_word_beat want;
            if (expected_beats.size() == 0) begin
                flag("beat with nothing pending (word)", 32'd0, got.word);
                return;
            end
            want = expected_beats.pop_front();
            if (got.word_valid !== want.word_valid)
                flag("word_valid", want.word_valid, got.word_valid);
            if (got.word !== want.word)
                flag("out_word", want.word, got.word);
            if (got.last !== want.last)
                flag("last", want.last, got.last);
            if (got.total_bits !== want.total_bits)
                flag("total_bits", want.total_bits, got.total_bits);
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [2:0]         i_operation = OP_PUT_BITS;
    logic signed [32:0] i_value = '0;
    logic [5:0]         i_bit_count = '0;
    logic               i_align_bit = 1'b0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic               o_word_valid;
    logic [31:0]        o_out_word;
    logic               o_last;
    logic [31:0]        o_total_bits;

    bitstream_scoreboard stream_check;
    bit                  sender_burst = 1'b0;
    bit                  receiver_burst = 1'b0;
    int                  cycle_cnt = 0;

    exp_golomb_bit_writer_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_operation  (i_operation),
        .i_value      (i_value),
        .i_bit_count  (i_bit_count),
        .i_align_bit  (i_align_bit),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_word_valid (o_word_valid),
        .o_out_word   (o_out_word),
        .o_last       (o_last),
        .o_total_bits (o_total_bits)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Draw an idle count; occasionally toggle into or out of a no-idle stretch
    function automatic int draw_idle(ref bit burst);
        if ($urandom_range(0, 49) == 0) burst = !burst;
        return burst ? 0 : $urandom_range(0, MAX_IDLE);
    endfunction

    // Offer one element after a random gap and hold it until the beat is taken
    task automatic send_element(input logic [2:0] op, input logic [32:0] value,
                                input logic [5:0] cnt, input logic abit);
        int       gap;
        t_element e;
        gap = draw_idle(sender_burst);
        e = '{op: op, value: value, bit_count: cnt, align_bit: abit};
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= e.op;
        i_value     <= e.value;
        i_bit_count <= e.bit_count;
        i_align_bit <= e.align_bit;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        stream_check.note_element(e);
    endtask

    // Random element, weighted toward codes and fields
    function automatic t_element rand_element();
        t_element e;
        int       r;
        r = $urandom_range(0, 99);
        if (r < 35)      e.op = OP_PUT_BITS;
        else if (r < 57) e.op = OP_UGOLOMB;
        else if (r < 79) e.op = OP_SGOLOMB;
        else if (r < 90) e.op = OP_ALIGN;
        else if (r < 97) e.op = OP_FLUSH;
        else             e.op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        case ($urandom_range(0, 3))
            0: begin
                e.value = 33'($urandom_range(0, 15));
                if ($urandom_range(0, 1)) e.value = -e.value;
            end
            1: e.value = {1'($urandom_range(0, 1)), $urandom()};
            2: begin
                case ($urandom_range(0, 5))
                    0: e.value = 33'h0_0000_0000;
                    1: e.value = 33'h0_0000_0001;
                    2: e.value = 33'h0_FFFF_FFFF;
                    3: e.value = 33'h1_0000_0000;
                    4: e.value = 33'h0_7FFF_FFFF;
                    default: e.value = 33'h1_FFFF_FFFF;
                endcase
            end
            default: begin
                e.value = {1'b0, $urandom() >> $urandom_range(0, 31)};
                if ($urandom_range(0, 1)) e.value = -e.value;
            end
        endcase
        r = $urandom_range(0, 99);
        if (r < 85)      e.bit_count = 6'($urandom_range(1, 32));
        else if (r < 92) e.bit_count = 6'd0;
        else             e.bit_count = 6'($urandom_range(33, 63));
        // field values are usually clean, sometimes carry junk above the field
        if (e.op == OP_PUT_BITS && $urandom_range(0, 2) != 0)
            e.value = e.value & ((33'd1 << e.bit_count) - 33'd1);
        e.align_bit = 1'($urandom_range(0, 1));
        return e;
    endfunction

    // Stimulus: reset, directed corners, then random elements, then drain
    initial begin : stimulus
        t_element e;
        stream_check = new();
        repeat (RESET_CYC) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_element(OP_FLUSH,    33'h0,           6'd0,  1'b0); // flush with nothing held
        send_element(OP_ALIGN,    33'h0,           6'd0,  1'b1); // already aligned
        send_element(OP_PUT_BITS, 33'h1_FFFF_FFFF, 6'd0,  1'b0); // empty field
        send_element(OP_PUT_BITS, 33'h0_FFFF_FFFF, 6'd32, 1'b0); // exactly one word
        send_element(OP_PUT_BITS, 33'h1_2345_6789, 6'd63, 1'b0); // count saturates
        send_element(OP_PUT_BITS, 33'h1_0000_001F, 6'd5,  1'b0);
        send_element(OP_ALIGN,    33'h0,           6'd0,  1'b1); // pad with ones
        send_element(OP_PUT_BITS, 33'h0,           6'd3,  1'b0);
        send_element(OP_ALIGN,    33'h1_FFFF_FFFF, 6'd0,  1'b0); // pad with zeros
        send_element(OP_UGOLOMB,  33'h0,           6'd0,  1'b0);
        send_element(OP_UGOLOMB,  33'h0_FFFF_FFFF, 6'd0,  1'b0); // saturated code
        send_element(OP_UGOLOMB,  33'h1_FFFF_FFFF, 6'd0,  1'b0); // negative, modulo 2^32
        send_element(OP_UGOLOMB,  33'h0_FFFF_FFFE, 6'd0,  1'b0);
        send_element(OP_SGOLOMB,  33'h0,           6'd0,  1'b0);
        send_element(OP_SGOLOMB,  33'h0_0000_0001, 6'd0,  1'b0);
        send_element(OP_SGOLOMB,  33'h1_FFFF_FFFF, 6'd0,  1'b0);
        send_element(OP_SGOLOMB,  33'h0_FFFF_FFFF, 6'd0,  1'b0); // largest positive
        send_element(OP_SGOLOMB,  33'h1_0000_0000, 6'd0,  1'b0); // most negative
        send_element(OP_SGOLOMB,  33'h0_7FFF_FFFF, 6'd0,  1'b0);
        send_element(OP_SPARE_FIRST, 33'h1_FFFF_FFFF, 6'd63, 1'b1);
        send_element(OP_SPARE_LAST,  33'h0_5555_5555, 6'd17, 1'b0);
        send_element(OP_PUT_BITS, 33'h1_AAAA_AAAA, 6'd33, 1'b1);
        send_element(OP_FLUSH,    33'h0,           6'd0,  1'b0); // partial word out
        send_element(OP_PUT_BITS, 33'h0_7FFF_FFFF, 6'd31, 1'b0);
        send_element(OP_PUT_BITS, 33'h0_0000_0001, 6'd1,  1'b0); // completes a word
        send_element(OP_FLUSH,    33'h0,           6'd0,  1'b1);

        for (int n = 0; n < RAND_ITEMS; n++) begin
            e = rand_element();
            send_element(e.op, e.value, e.bit_count, e.align_bit);
        end
        i_valid <= 1'b0;

        while (stream_check.expected_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (stream_check.mismatch_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Result side: random stalls, one long hold-off to back the block up
    initial begin : receiver
        int         stall;
        int         beats_seen;
        t_word_beat got;
        beats_seen = 0;
        wait (i_rst_n);
        forever begin
            if (beats_seen == HOLD_AT) stall = HOLD_CYC;
            else stall = draw_idle(receiver_burst);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            got = '{word_valid: o_word_valid, word: o_out_word,
                    last: o_last, total_bits: o_total_bits};
            stream_check.check_word_beat(got);
            beats_seen++;
        end
    end

    // Watchdog
    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
